// ===== src/tism_pkg.sv =====
package tism_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Word field widths
    localparam int COUNT_W       = 7;
    localparam int KIND_W        = 1;
    localparam int ENTRY_INDEX_W = 6;
    localparam int CONC_W        = 15;
    localparam int DENS_W        = 16;
    localparam int VOL_W         = 20;
    localparam int MASS_W        = 32;
    localparam int STATUS_W      = 2;

    // Arithmetic
    localparam int VD_W              = VOL_W + DENS_W;
    localparam int MASS_PROD_W       = VD_W + CONC_W;
    localparam int MASS_SHIFT        = 16;
    localparam int PERCENT_SCALE     = 100;
    localparam int DIV_NUM_W         = 36;
    localparam int DIV_DEN_W         = 16;
    localparam int DIV_BITS_PER_STEP = 2;
    localparam int DIV_STEPS         = DIV_NUM_W / DIV_BITS_PER_STEP;
    localparam int DIV_CNT_W         = $clog2(DIV_STEPS + 1);

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_TABLE_COUNT = '0;

    // Input kind codes
    localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WRITTEN = 2'd2;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_SKIP_WRITE,
        CMD_QUERY,
        CMD_EMPTY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic                empty_hit;
        logic [IDX_W-1:0]    idx;
        logic [CONC_W-1:0]   conc;
        logic [DENS_W-1:0]   dens;
        logic [CONC_W-1:0]   tgt;
        logic [VOL_W-1:0]    vol;
        logic [CNT_W-1:0]    n;
    } cmd_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_INT_MUL,
        BK_INT_WAIT,
        BK_VD_MUL,
        BK_T_MUL,
        BK_MASS_WAIT,
        BK_DONE
    } back_state_t;

endpackage

// ===== src/tism_if.sv =====
interface tism_in_if;
    import tism_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [CONC_W-1:0]        entry_conc;
    logic [DENS_W-1:0]        entry_density;
    logic [CONC_W-1:0]        target_conc;
    logic [VOL_W-1:0]         volume;

    modport source (
        output valid, kind, entry_index, entry_conc, entry_density, target_conc, volume,
        input  ready
    );

    modport sink (
        input  valid, kind, entry_index, entry_conc, entry_density, target_conc, volume,
        output ready
    );
endinterface

interface tism_out_if;
    import tism_pkg::*;

    logic                valid;
    logic                ready;
    logic [MASS_W-1:0]   solute_mass;
    logic [DENS_W-1:0]   density_found;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, solute_mass, density_found, status,
        input  ready
    );

    modport sink (
        input  valid, solute_mass, density_found, status,
        output ready
    );
endinterface

// ===== src/tism_front.sv =====
module tism_front
    import tism_pkg::*;
(
    tism_in_if.sink             req,
    input  logic [COUNT_W-1:0]  table_count,
    input  logic                q_full,
    output logic                push,
    output cmd_t                cmd
);

    logic [CNT_W-1:0] n;
    logic             in_range;

    always_comb
    begin
        req.ready = !q_full;
        push      = req.valid && !q_full;

        // clamp the scan length to the table depth
        if (32'(table_count) > 32'(TABLE_DEPTH))
        begin
            n = CNT_W'(TABLE_DEPTH);
        end
        else
        begin
            n = CNT_W'(table_count);
        end

        in_range = 32'(req.entry_index) < 32'(TABLE_DEPTH);

        cmd.idx       = IDX_W'(req.entry_index);
        cmd.conc      = req.entry_conc;
        cmd.dens      = req.entry_density;
        cmd.tgt       = req.target_conc;
        cmd.vol       = req.volume;
        cmd.n         = n;
        cmd.empty_hit = (req.target_conc == '0);

        unique case (req.kind)
            KIND_WRITE:
            begin
                cmd.kind = in_range ? CMD_WRITE : CMD_SKIP_WRITE;
            end
            KIND_QUERY:
            begin
                // an empty table settles the query without a scan
                cmd.kind = (n == '0) ? CMD_EMPTY : CMD_QUERY;
            end
            default:
            begin
                cmd.kind = CMD_SKIP_WRITE;
            end
        endcase
    end

endmodule

// ===== src/tism_fifo.sv =====
module tism_fifo
    import tism_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb
    begin
        full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
        empty   = (cnt_reg == '0);
        pop_cmd = slot_reg[rd_ptr_reg];

        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/tism_div.sv =====
module tism_div
    import tism_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W:0]   rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    // restoring division, two quotient bits a cycle
    always_comb
    begin
        logic [DIV_DEN_W:0]   r;
        logic [DIV_NUM_W-1:0] q;

        r = rem_reg;
        q = quo_reg;
        for (int k = 0; k < DIV_BITS_PER_STEP; k++)
        begin
            r = {r[DIV_DEN_W-1:0], q[DIV_NUM_W-1]};
            q = {q[DIV_NUM_W-2:0], 1'b0};
            if (r >= {1'b0, den_reg})
            begin
                r    = r - {1'b0, den_reg};
                q[0] = 1'b1;
            end
        end

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = q;
            rem_next = r;
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end

        rsp.busy = busy_reg;
        rsp.done = done_reg;
        rsp.quot = quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

endmodule

// ===== src/tism_back.sv =====
module tism_back
    import tism_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_empty,
    input  cmd_t     q_cmd,
    output logic     pop,
    output div_req_t div_req,
    input  div_rsp_t div_rsp,
    tism_out_if.source rsp
);

    logic [CONC_W-1:0] conc_mem [TABLE_DEPTH];
    logic [DENS_W-1:0] dens_mem [TABLE_DEPTH];
    logic [CONC_W-1:0] rd_conc_reg;
    logic [DENS_W-1:0] rd_dens_reg;
    logic              mem_we;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    back_state_t         state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic [CNT_W-1:0]    eval_reg, eval_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [CONC_W-1:0]   c_prev_reg, c_prev_next;
    logic [DENS_W-1:0]   d_prev_reg, d_prev_next;
    logic [CONC_W-1:0]   c_ent_reg, c_ent_next;
    logic [DENS_W-1:0]   d_ent_reg, d_ent_next;
    logic [DENS_W-1:0]   dens_reg, dens_next;
    logic [VD_W-1:0]     vd_reg, vd_next;
    logic [MASS_W-1:0]   res_mass_reg, res_mass_next;
    logic [DENS_W-1:0]   res_dens_reg, res_dens_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [MASS_W-1:0]   out_mass_reg, out_mass_next;
    logic [DENS_W-1:0]   out_dens_reg, out_dens_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic [CONC_W-1:0]                  dc;
    logic [CONC_W-1:0]                  span;
    logic [DENS_W:0]                    dd;
    logic [DENS_W-1:0]                  dd_mag;
    logic [CONC_W+DENS_W-1:0]           int_prod;
    logic [MASS_PROD_W-1:0]             mass_prod;
    logic [MASS_PROD_W-MASS_SHIFT-1:0]  mass_num;
    logic [DENS_W-1:0]                  q_dens;
    logic                               hit_exact;
    logic                               hit_seg;
    logic                               load_out;

    always_comb
    begin
        dc       = cmd_reg.tgt - c_prev_reg;
        span     = c_ent_reg - c_prev_reg;
        dd       = {1'b0, d_ent_reg} - {1'b0, d_prev_reg};
        dd_mag   = dd[DENS_W] ? DENS_W'(-dd) : dd[DENS_W-1:0];
        int_prod = (CONC_W+DENS_W)'(dc) * (CONC_W+DENS_W)'(dd_mag);
        mass_prod = MASS_PROD_W'(vd_reg) * MASS_PROD_W'(cmd_reg.tgt);
        mass_num  = mass_prod[MASS_PROD_W-1:MASS_SHIFT];
        q_dens    = div_rsp.quot[DENS_W-1:0];

        hit_exact = (rd_conc_reg == cmd_reg.tgt);
        hit_seg   = (cmd_reg.tgt > c_prev_reg) && (cmd_reg.tgt < rd_conc_reg);

        state_next      = state_reg;
        cmd_next        = cmd_reg;
        issue_next      = issue_reg;
        eval_next       = eval_reg;
        rd_valid_next   = 1'b0;
        c_prev_next     = c_prev_reg;
        d_prev_next     = d_prev_reg;
        c_ent_next      = c_ent_reg;
        d_ent_next      = d_ent_reg;
        dens_next       = dens_reg;
        vd_next         = vd_reg;
        res_mass_next   = res_mass_reg;
        res_dens_next   = res_dens_reg;
        res_status_next = res_status_reg;
        pop             = 1'b0;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = issue_reg[IDX_W-1:0];
        div_req.start   = 1'b0;
        div_req.num     = DIV_NUM_W'(int_prod);
        div_req.den     = DIV_DEN_W'(span);
        load_out        = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop           = 1'b1;
                    cmd_next      = q_cmd;
                    res_mass_next = '0;
                    res_dens_next = '0;
                    unique case (q_cmd.kind)
                        CMD_WRITE:
                        begin
                            mem_we          = 1'b1;
                            res_status_next = ST_WRITTEN;
                            state_next      = BK_DONE;
                        end
                        CMD_SKIP_WRITE:
                        begin
                            res_status_next = ST_WRITTEN;
                            state_next      = BK_DONE;
                        end
                        CMD_EMPTY:
                        begin
                            res_status_next = q_cmd.empty_hit ? ST_OK : ST_RANGE;
                            state_next      = BK_DONE;
                        end
                        CMD_QUERY:
                        begin
                            issue_next  = '0;
                            eval_next   = '0;
                            c_prev_next = '0;
                            d_prev_next = '0;
                            state_next  = BK_SCAN;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end

            BK_SCAN:
            begin
                // prefetch one entry ahead of the compare
                rd_en = (issue_reg < cmd_reg.n);
                if (rd_en)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                rd_valid_next = rd_en;
                if (rd_valid_reg)
                begin
                    if (hit_exact)
                    begin
                        dens_next     = rd_dens_reg;
                        rd_valid_next = 1'b0;
                        state_next    = BK_VD_MUL;
                    end
                    else if (hit_seg)
                    begin
                        c_ent_next    = rd_conc_reg;
                        d_ent_next    = rd_dens_reg;
                        rd_valid_next = 1'b0;
                        state_next    = BK_INT_MUL;
                    end
                    else
                    begin
                        c_prev_next = rd_conc_reg;
                        d_prev_next = rd_dens_reg;
                        eval_next   = eval_reg + CNT_W'(1);
                        if (eval_reg == cmd_reg.n - CNT_W'(1))
                        begin
                            res_mass_next   = '0;
                            res_dens_next   = '0;
                            res_status_next = ST_RANGE;
                            rd_valid_next   = 1'b0;
                            state_next      = BK_DONE;
                        end
                    end
                end
            end

            BK_INT_MUL:
            begin
                div_req.start = 1'b1;
                state_next    = BK_INT_WAIT;
            end

            BK_INT_WAIT:
            begin
                if (div_rsp.done)
                begin
                    // quotient magnitude stays below |dd|, so no wrap either way
                    dens_next  = dd[DENS_W] ? d_prev_reg - q_dens : d_prev_reg + q_dens;
                    state_next = BK_VD_MUL;
                end
            end

            BK_VD_MUL:
            begin
                vd_next    = VD_W'(cmd_reg.vol) * VD_W'(dens_reg);
                state_next = BK_T_MUL;
            end

            BK_T_MUL:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NUM_W'(mass_num);
                div_req.den   = DIV_DEN_W'(PERCENT_SCALE);
                state_next    = BK_MASS_WAIT;
            end

            BK_MASS_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (|div_rsp.quot[DIV_NUM_W-1:MASS_W])
                    begin
                        res_mass_next = '1;
                    end
                    else
                    begin
                        res_mass_next = div_rsp.quot[MASS_W-1:0];
                    end
                    res_dens_next   = dens_reg;
                    res_status_next = ST_OK;
                    state_next      = BK_DONE;
                end
            end

            BK_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        out_mass_next   = out_mass_reg;
        out_dens_next   = out_dens_reg;
        out_status_next = out_status_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_mass_next   = res_mass_reg;
            out_dens_next   = res_dens_reg;
            out_status_next = res_status_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        rsp.valid         = out_valid_reg;
        rsp.solute_mass   = out_mass_reg;
        rsp.density_found = out_dens_reg;
        rsp.status        = out_status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            issue_reg     <= '0;
            eval_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            eval_reg      <= eval_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        c_prev_reg     <= c_prev_next;
        d_prev_reg     <= d_prev_next;
        c_ent_reg      <= c_ent_next;
        d_ent_reg      <= d_ent_next;
        dens_reg       <= dens_next;
        vd_reg         <= vd_next;
        res_mass_reg   <= res_mass_next;
        res_dens_reg   <= res_dens_next;
        res_status_reg <= res_status_next;
        out_mass_reg   <= out_mass_next;
        out_dens_reg   <= out_dens_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            conc_mem[q_cmd.idx] <= q_cmd.conc;
            dens_mem[q_cmd.idx] <= q_cmd.dens;
        end
        if (rd_en)
        begin
            rd_conc_reg <= conc_mem[rd_addr];
            rd_dens_reg <= dens_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_span_positive: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_INT_MUL |-> c_ent_reg > c_prev_reg)
        else $error("interpolation span not positive");

    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_scan_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SCAN && rd_valid_reg) |-> eval_reg < cmd_reg.n)
        else $error("scan compared past the table length");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> (out_valid_reg && $stable(out_mass_reg)))
        else $error("waiting result overwritten");
`endif

endmodule

// ===== src/table_interp_solute_mass.sv =====
// Piecewise linear density lookup with solute mass. Words on req either load one
// table slot (kind 0) or query a concentration and volume (kind 1); every word gives
// exactly one result word on rsp, in order. A query walks the first table_count
// slots from an implicit (0,0) point, stops at an exact concentration match or the
// first enclosing segment, interpolates the density (truncated toward zero) and
// returns volume * density * concentration / 100 in 1/256 g, truncated and
// saturated at 32 bits; with no stop it returns status 1. The table memory is not
// cleared at reset, so slots must be written before a query reaches them. The scan
// reads one slot a cycle through the single memory read port, and the shared
// two-bit-per-cycle divider runs for the interpolation and again for the divide
// by 100. An empty-table query is settled without a scan. A two-word command queue
// sits between the accepting front and the executing back, so req keeps taking
// words while a result waits on rsp, until the queue is full. Set table_count at
// address 0 only while the block is idle.
module table_interp_solute_mass
    import tism_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    tism_in_if.sink            req,
    tism_out_if.source         rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               reg_hit;
    logic               push;
    cmd_t               push_cmd;
    logic               q_full;
    logic               q_empty;
    logic               pop;
    cmd_t               pop_cmd;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // register port: word-aligned decode, low address bits ignored
    always_comb
    begin
        pready     = 1'b1;
        reg_hit    = (paddr[PADDR_W-1:2] == REG_TABLE_COUNT);
        count_next = count_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            count_next = pwdata[COUNT_W-1:0];
        end
        prdata = reg_hit ? PDATA_W'(count_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // classify words into commands
    tism_front u_front (
        .req         (req),
        .table_count (count_reg),
        .q_full      (q_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    // hold commands between front and back
    tism_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    // shared divider for interpolation and the percent scale
    tism_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // table memory, scan, arithmetic and result register
    tism_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_cmd   (pop_cmd),
        .pop     (pop),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .rsp     (rsp)
    );

endmodule

// ===== bench/table_interp_solute_mass_tb.sv =====
module table_interp_solute_mass_tb;
    import tism_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One request word as the bench sees it; every field is driven on every word,
    // whether the block uses it or not.
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [ENTRY_INDEX_W-1:0] idx;
        logic [CONC_W-1:0]        econc;
        logic [DENS_W-1:0]        edens;
        logic [CONC_W-1:0]        tgt;
        logic [VOL_W-1:0]         vol;
    } word_t;

    // One response word: mass, density used and status.
    typedef struct packed {
        logic [MASS_W-1:0]   mass;
        logic [DENS_W-1:0]   dens;
        logic [STATUS_W-1:0] status;
    } mass_res_t;

    // Volume is in 1/16 mL, density in Q4.12, percent needs dividing by 100.
    localparam longint MASS_DIV      = 64'd16 * 64'd4096 * PERCENT_SCALE;
    localparam int     RANDOM_WORDS  = 700;
    localparam int     STALL_LIMIT   = 4000;
    localparam int     SETTLE_CYCLES = 150;
    localparam int     REPORT_MAX    = 10;
    localparam int     CONC_MAX      = 32767;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tism_in_if  req_if ();
    tism_out_if rsp_if ();

    table_interp_solute_mass DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mirror of the block: its table columns and the count register as last written.
    logic [CONC_W-1:0]  conc_col [TABLE_DEPTH];
    logic [DENS_W-1:0]  dens_col [TABLE_DEPTH];
    logic [COUNT_W-1:0] count_setting;

    // Concentrations as planned at queue time, used only to aim queries at the table.
    logic [CONC_W-1:0]  plan_conc [TABLE_DEPTH];

    word_t     pending_words [$];   // words waiting for the driver
    mass_res_t due_results [$];     // results owed by the block, oldest first
    word_t     on_wire;             // word currently presented on req
    word_t     next_word;
    mass_res_t got;
    mass_res_t want;

    int  planned;
    int  fault_count;
    int  gap_left;
    int  stall_left;
    int  idle_cycles;
    bit  src_idle;
    bit  snk_idle;

    // Work out the result of one accepted word and apply its effect on the table.
    function automatic mass_res_t lookup_mass(input word_t w);
        mass_res_t r;
        int        n;
        bit        hit;
        longint    tgt;
        longint    c_prev;
        longint    d_prev;
        longint    c_ent;
        longint    d_ent;
        longint    span;
        longint    dens;
        longint    mass;
        r = '0;
        if (w.kind == KIND_WRITE)
        begin
            // Index is six bits wide, so every slot named exists.
            conc_col[w.idx] = w.econc;
            dens_col[w.idx] = w.edens;
            r.status = ST_WRITTEN;
            return r;
        end
        n = (count_setting > TABLE_DEPTH) ? TABLE_DEPTH : count_setting;
        tgt = w.tgt;
        c_prev = 0;
        d_prev = 0;
        c_ent = 0;
        d_ent = 0;
        hit = 1'b0;
        // Walk from the implied origin; stop on an exact match or an enclosing segment.
        for (int i = 0; i < n; i++)
        begin
            c_ent = conc_col[i];
            d_ent = dens_col[i];
            if ((tgt > c_prev && tgt < c_ent) || c_ent == tgt)
            begin
                hit = 1'b1;
                break;
            end
            c_prev = c_ent;
            d_prev = d_ent;
        end
        // An empty table still answers a zero target from the origin itself.
        if (n == 0 && tgt == 0)
            hit = 1'b1;
        if (!hit)
        begin
            r.status = ST_RANGE;
            return r;
        end
        if (c_ent == tgt)
            dens = d_ent;
        else
        begin
            span = c_ent - c_prev;
            if (span <= 0)
            begin
                r.status = ST_RANGE;
                return r;
            end
            // Signed division truncates toward zero, as the block does.
            dens = d_prev + ((tgt - c_prev) * (d_ent - d_prev)) / span;
        end
        if (dens < 0)
            dens = 0;
        if (dens > 65535)
            dens = 65535;
        mass = (longint'(w.vol) * dens * tgt) / MASS_DIV;
        if (mass > 64'hFFFF_FFFF)
            mass = 64'hFFFF_FFFF;
        r.mass = mass[MASS_W-1:0];
        r.dens = dens[DENS_W-1:0];
        r.status = ST_OK;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic word_t noise_word();
        word_t w;
        w.kind = $urandom;
        w.idx = $urandom;
        w.econc = $urandom;
        w.edens = $urandom;
        w.tgt = $urandom;
        w.vol = $urandom;
        return w;
    endfunction

    // Aim a query at the table: exact hits, inside the span, zero, past the top, anywhere.
    function automatic word_t make_query(input int rows);
        word_t w;
        int    top;
        int    r;
        w = noise_word();
        w.kind = KIND_QUERY;
        top = 0;
        for (int i = 0; i < rows; i++)
            if (plan_conc[i] > top)
                top = plan_conc[i];
        r = $urandom_range(0, 99);
        if (r < 35 && rows != 0)
            w.tgt = plan_conc[$urandom_range(0, rows - 1)];
        else if (r < 75)
            w.tgt = $urandom_range(0, (top == 0) ? 25600 : top);
        else if (r < 82)
            w.tgt = '0;
        else if (r < 90 && top < CONC_MAX)
            w.tgt = $urandom_range(top + 1, CONC_MAX);
        r = $urandom_range(0, 9);
        if (r == 0)
            w.vol = '0;
        else if (r == 1)
            w.vol = '1;
        return w;
    endfunction

    function automatic void plan_word(input word_t w);
        if (w.kind == KIND_WRITE)
            plan_conc[w.idx] = w.econc;
        pending_words.push_back(w);
        planned++;
    endfunction

    function automatic void note_fault(input string what, input mass_res_t exp_r,
                                       input mass_res_t act_r);
        fault_count++;
        if (fault_count <= REPORT_MAX)
            $display("%t %s: mass %0d/%0d density %0d/%0d status %0d/%0d (expected/actual)",
                     $realtime, what, exp_r.mass, act_r.mass, exp_r.dens, act_r.dens,
                     exp_r.status, act_r.status);
    endfunction

    // Fill slots 0..rows-1, ascending unless a scrambled table is asked for.
    task automatic load_table(input int rows, input bit scrambled);
        word_t w;
        int    c;
        int    step;
        step = (rows == 0) ? 1 : CONC_MAX / rows;
        c = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, step);
        for (int i = 0; i < rows; i++)
        begin
            w = noise_word();
            w.kind = KIND_WRITE;
            w.idx = i;
            if (!scrambled)
            begin
                w.econc = c;
                c = c + $urandom_range(1, step);
            end
            else if (i > 0 && $urandom_range(0, 4) == 0)
                w.econc = plan_conc[i - 1];
            plan_word(w);
        end
    endtask

    // Hold until nothing is queued, on the wire or owed, then let the block settle.
    // Sample on the falling edge so that posedge updates have all landed.
    task automatic drain();
        @(negedge clk);
        while (pending_words.size() != 0 || due_results.size() != 0 || req_if.valid)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value on the access edge.
    task automatic reg_write(input logic [COUNT_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_TABLE_COUNT, 2'b00};
        pwdata <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        count_setting = value;
    endtask

    // Driver: predict on acceptance, then present the next word or hold a gap.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
                due_results.push_back(lookup_mass(on_wire));
            if (!req_if.valid || req_if.ready)
            begin
                if (gap_left != 0)
                begin
                    req_if.valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_words.size() != 0)
                begin
                    next_word = pending_words.pop_front();
                    on_wire <= next_word;
                    req_if.kind <= next_word.kind;
                    req_if.entry_index <= next_word.idx;
                    req_if.entry_conc <= next_word.econc;
                    req_if.entry_density <= next_word.edens;
                    req_if.target_conc <= next_word.tgt;
                    req_if.volume <= next_word.vol;
                    req_if.valid <= 1'b1;
                    gap_left <= (src_idle && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result against the oldest one owed, and stall at random.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = {rsp_if.solute_mass, rsp_if.density_found, rsp_if.status};
                if (due_results.size() == 0)
                    note_fault("result with nothing owed", '0, got);
                else
                begin
                    want = due_results.pop_front();
                    if (got.mass !== want.mass || got.dens !== want.dens ||
                        got.status !== want.status)
                        note_fault("result mismatch", want, got);
                end
            end
            if (stall_left != 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (snk_idle && $urandom_range(0, 99) < 15)
            begin
                rsp_if.ready <= 1'b0;
                stall_left <= pick_gap() - 1;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // Count cycles with no word moving anywhere; a hang trips the watchdog below.
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (psel && penable) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("FAIL table_interp_solute_mass");
        $finish;
    end

    initial
    begin
        word_t w;
        int    rows;
        logic [COUNT_W-1:0] count_pick;

        // Drive every input to a known value before the first edge.
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.kind = '0;
        req_if.entry_index = '0;
        req_if.entry_conc = '0;
        req_if.entry_density = '0;
        req_if.target_conc = '0;
        req_if.volume = '0;
        rsp_if.ready = 1'b0;
        on_wire = '0;
        count_setting = '0;
        planned = 0;
        fault_count = 0;
        idle_cycles = 0;
        src_idle = 1'b1;
        snk_idle = 1'b1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table after reset: a zero target resolves at the origin, any other
        // target is out of range.
        w = noise_word();
        w.kind = KIND_QUERY;
        w.tgt = '0;
        plan_word(w);
        w = noise_word();
        w.kind = KIND_QUERY;
        w.tgt = 15'd5;
        plan_word(w);
        drain();

        // Small hand-built table: a rising, a falling and a dropping-to-zero segment, with the
        // widest concentration in the last slot and the widest density in slot 2.
        reg_write(7'd4);
        w = noise_word();
        w.kind = KIND_WRITE;
        w.idx = 6'd0; w.econc = 15'd256;   w.edens = 16'd4096;  plan_word(w);
        w.idx = 6'd1; w.econc = 15'd2560;  w.edens = 16'd3000;  plan_word(w);
        w.idx = 6'd2; w.econc = 15'd12800; w.edens = 16'hFFFF;  plan_word(w);
        w.idx = 6'd3; w.econc = 15'h7FFF;  w.edens = 16'd0;     plan_word(w);
        w = noise_word();
        w.kind = KIND_QUERY;
        w.tgt = 15'd256;   w.vol = 20'd16;    plan_word(w);   // exact hit, first slot
        w.tgt = 15'd100;   w.vol = 20'd1600;  plan_word(w);   // between origin and slot 0
        w.tgt = 15'd1000;  w.vol = 20'd4000;  plan_word(w);   // falling density segment
        w.tgt = 15'd12800; w.vol = '1;        plan_word(w);   // largest mass
        w.tgt = 15'd20000; w.vol = '1;        plan_word(w);   // density heading for zero
        w.tgt = 15'h7FFF;  w.vol = '1;        plan_word(w);   // top concentration, zero density
        w.tgt = '0;        w.vol = 20'd100;   plan_word(w);   // no zero entry: out of range
        w.tgt = 15'd25600; w.vol = '0;        plan_word(w);   // zero volume
        w.tgt = 15'd2559;  w.vol = 20'h5A5A5; plan_word(w);
        // Top slot with every data bit set, outside the scanned range.
        w = noise_word();
        w.kind = KIND_WRITE;
        w.idx = '1;
        w.econc = '1;
        w.edens = '1;
        plan_word(w);

        // Random phases: fresh count, load the table, then a burst of queries with a
        // few stray writes mixed in. Each phase starts only once the block has drained.
        for (int p = 0; planned < RANDOM_WORDS + 25; p++)
        begin
            case (p)
                0:       count_pick = TABLE_DEPTH;
                1:       count_pick = '1;                  // above depth: clamps
                2:       count_pick = '0;
                3:       count_pick = TABLE_DEPTH + 1;
                4:       count_pick = 7'd1;
                default: count_pick = ($urandom_range(0, 7) == 0) ?
                                      $urandom_range(13, TABLE_DEPTH) : $urandom_range(1, 12);
            endcase
            drain();
            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            reg_write(count_pick);
            rows = (count_pick > TABLE_DEPTH) ? TABLE_DEPTH : count_pick;
            load_table(rows, (p % 5 == 4) || ($urandom_range(0, 9) == 0));
            repeat ($urandom_range(16, 40))
            begin
                if ($urandom_range(0, 99) < 8)
                begin
                    w = noise_word();
                    w.kind = KIND_WRITE;
                    plan_word(w);
                end
                else
                    plan_word(make_query(rows));
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        fault_count += due_results.size();
        if (fault_count == 0)
            $display("PASS table_interp_solute_mass");
        else
            $display("FAIL table_interp_solute_mass");
        $finish;
    end

endmodule
